### src/dhcp_rx_pkg.sv
`default_nettype none
package dhcp_rx_pkg;
  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_EMPTY = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    V_TRUNC   = 3'd0,
    V_NOT_IP  = 3'd1,
    V_NOT_UDP = 3'd2,
    V_NOT_DH  = 3'd3,
    V_BAD_CK  = 3'd4,
    V_DHCP_OK = 3'd5,
    V_COUNTER = 3'd6
  } verdict_t;

  typedef enum logic [2:0] {
    OPT_CODE  = 3'd0,
    OPT_LEN   = 3'd1,
    OPT_SKIP  = 3'd2,
    OPT_VALUE = 3'd3,
    OPT_DONE  = 3'd4
  } opt_state_t;

  localparam int NUM_CNT = 10;
  localparam logic [3:0] CNT_FRAMES = 4'd0;
  localparam logic [3:0] CNT_TRUNC  = 4'd1;
  localparam logic [3:0] CNT_IPV4   = 4'd2;
  localparam logic [3:0] CNT_UDP    = 4'd3;
  localparam logic [3:0] CNT_DHCP   = 4'd4;
  localparam logic [3:0] CNT_BADCK  = 4'd5;
  localparam logic [3:0] CNT_OFFER  = 4'd6;
  localparam logic [3:0] CNT_ACK    = 4'd7;
  localparam logic [3:0] CNT_NAK    = 4'd8;
  localparam logic [3:0] CNT_GEN    = 4'd9;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [15:0] PORT_SRV = 16'd67;
  localparam logic [15:0] PORT_CLI = 16'd68;
  localparam logic [31:0] MAGIC_COOKIE = 32'h63825363;
  localparam logic [7:0]  OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0]  OPT_END = 8'd255;
  localparam logic [7:0]  OPT_PAD = 8'd0;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [7:0] iface;
    logic [7:0] dst_idx;
    logic [3:0] counter_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [7:0]  dhcp_type;
    logic [31:0] xid;
    logic [47:0] client_hw_addr;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] udp_sport;
    logic [15:0] udp_dport;
    logic [47:0] dest_mac;
    logic [7:0]  last_iface;
    logic [7:0]  last_dst_idx;
    logic [31:0] counter_value;
  } out_item_t;

  // frame capture handed from the parser to the commit stage
  typedef struct packed {
    logic [47:0] dest_mac;
    logic [15:0] ethertype;
    logic [7:0]  ip_byte0;
    logic [7:0]  proto;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] udp_sport;
    logic [15:0] udp_dport;
    logic [31:0] xid;
    logic [47:0] chaddr;
    logic [31:0] cookie;
    logic        found;
    logic [7:0]  mtype;
  } capture_t;
endpackage
`default_nettype wire

### src/dhcp_rx_parser.sv
`default_nettype none
module dhcp_rx_parser
  import dhcp_rx_pkg::*;
#(
  parameter int MAX_FRAME_LEN = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_en,
  input  wire logic        restart,
  input  wire logic [7:0]  b,
  output capture_t         cap_next,
  output logic [15:0]      len_next
);
  logic [15:0] pos;
  capture_t cap;
  opt_state_t ost;
  logic [7:0] opt_code;
  logic [7:0] skip_left;

  logic [15:0] pos_next;
  opt_state_t ost_next;
  logic [7:0] opt_code_next, skip_left_next;
  logic [6:0] hlen;
  logic [16:0] p, u, d;
  logic take;

  always_comb begin
    cap_next       = cap;
    pos_next       = pos;
    ost_next       = ost;
    opt_code_next  = opt_code;
    skip_left_next = skip_left;
    p    = {1'b0, pos};
    take = byte_en && (p < 17'(MAX_FRAME_LEN));
    if (take) begin
      if (p < 17'd6) cap_next.dest_mac = {cap.dest_mac[39:0], b};
      if (p == 17'd12 || p == 17'd13) cap_next.ethertype = {cap.ethertype[7:0], b};
      if (p == 17'd14) cap_next.ip_byte0 = b;
      if (p == 17'd23) cap_next.proto = b;
      if (p >= 17'd26 && p < 17'd30) cap_next.src_ip = {cap.src_ip[23:0], b};
      if (p >= 17'd30 && p < 17'd34) cap_next.dst_ip = {cap.dst_ip[23:0], b};
    end
    // port and dhcp offsets follow the header length, already valid at byte 14
    hlen = {1'b0, cap_next.ip_byte0[3:0], 2'b00};
    u = 17'd14 + 17'(hlen);
    d = u + 17'd8;
    if (take) begin
      if (p >= u && p < u + 17'd2) cap_next.udp_sport = {cap.udp_sport[7:0], b};
      if (p >= u + 17'd2 && p < u + 17'd4) cap_next.udp_dport = {cap.udp_dport[7:0], b};
      if (p >= d + 17'd4 && p < d + 17'd8) cap_next.xid = {cap.xid[23:0], b};
      if (p >= d + 17'd28 && p < d + 17'd34) cap_next.chaddr = {cap.chaddr[39:0], b};
      if (p >= d + 17'd236 && p < d + 17'd240) cap_next.cookie = {cap.cookie[23:0], b};
      if (p >= d + 17'd240) begin
        case (ost)
          OPT_CODE: begin
            if (b == OPT_END) ost_next = OPT_DONE;
            else if (b != OPT_PAD) begin
              opt_code_next = b;
              ost_next = OPT_LEN;
            end
          end
          OPT_LEN: begin
            if (opt_code == OPT_MSG_TYPE && b == 8'd1) ost_next = OPT_VALUE;
            else if (b == 8'd0) ost_next = OPT_CODE;
            else begin
              skip_left_next = b;
              ost_next = OPT_SKIP;
            end
          end
          OPT_SKIP: begin
            skip_left_next = skip_left - 8'd1;
            if (skip_left == 8'd1) ost_next = OPT_CODE;
          end
          OPT_VALUE: begin
            cap_next.mtype = b;
            cap_next.found = 1'b1;
            ost_next = OPT_DONE;
          end
          default: ;
        endcase
      end
      pos_next = pos + 16'd1;
    end
  end

  assign len_next = pos_next;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pos       <= '0;
      cap       <= '0;
      ost       <= OPT_CODE;
      opt_code  <= '0;
      skip_left <= '0;
    end else begin
      pos       <= pos_next;
      cap       <= cap_next;
      ost       <= ost_next;
      opt_code  <= opt_code_next;
      skip_left <= skip_left_next;
    end
  end
endmodule
`default_nettype wire

### src/dhcp_rx_commit.sv
`default_nettype none
module dhcp_rx_commit
  import dhcp_rx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire logic        commit,
  input  wire logic        empty,
  input  wire logic        read,
  input  wire logic        clear,
  input  wire capture_t    cap,
  input  wire logic [15:0] len,
  input  wire logic [7:0]  iface,
  input  wire logic [7:0]  dst_idx,
  input  wire logic [3:0]  counter_index,
  output out_item_t        res
);
  logic [31:0] cnt [NUM_CNT];
  out_item_t seen;
  out_item_t seen_next;
  logic [NUM_CNT-1:0] inc;
  logic [2:0] v;
  logic [16:0] l, hl, need;
  logic [7:0] mtype;

  always_comb begin
    seen_next = seen;
    inc = '0;
    v = V_TRUNC;
    l = (empty) ? 17'd0 : {1'b0, len};
    hl = 17'({cap.ip_byte0[3:0], 2'b00});
    need = 17'd22 + hl;
    mtype = cap.found ? cap.mtype : 8'd0;
    if (commit) begin
      inc[CNT_FRAMES] = 1'b1;
      if (l < 17'd14) begin
        inc[CNT_TRUNC] = 1'b1;
      end else begin
        seen_next.dest_mac = cap.dest_mac;
        seen_next.last_iface = iface;
        seen_next.last_dst_idx = dst_idx;
        if (cap.ethertype != ETH_IPV4) v = V_NOT_IP;
        else begin
          inc[CNT_IPV4] = 1'b1;
          if (l < 17'd34 || cap.ip_byte0[7:4] != 4'd4 || hl < 17'd20 || l < need) begin
            inc[CNT_TRUNC] = 1'b1;
          end else begin
            seen_next.src_ip = cap.src_ip;
            seen_next.dst_ip = cap.dst_ip;
            if (cap.proto != PROTO_UDP) v = V_NOT_UDP;
            else begin
              inc[CNT_UDP] = 1'b1;
              seen_next.udp_sport = cap.udp_sport;
              seen_next.udp_dport = cap.udp_dport;
              if (cap.udp_sport != PORT_SRV || cap.udp_dport != PORT_CLI) v = V_NOT_DH;
              else begin
                inc[CNT_DHCP] = 1'b1;
                if (l - need < 17'd240 || cap.cookie != MAGIC_COOKIE) begin
                  inc[CNT_BADCK] = 1'b1;
                  v = V_BAD_CK;
                end else begin
                  v = V_DHCP_OK;
                  seen_next.xid = cap.xid;
                  seen_next.dhcp_type = mtype;
                  seen_next.client_hw_addr = cap.chaddr;
                  if (mtype == 8'd2) inc[CNT_OFFER] = 1'b1;
                  else if (mtype == 8'd5) inc[CNT_ACK] = 1'b1;
                  else if (mtype == 8'd6) inc[CNT_NAK] = 1'b1;
                end
              end
            end
          end
        end
      end
    end
    res = seen_next;
    res.verdict = read ? V_COUNTER : v;
    res.counter_value = (read && counter_index < 4'(NUM_CNT)) ? cnt[counter_index] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
      for (int i = 0; i < NUM_CNT; i++) cnt[i] <= '0;
    end else if (go && clear) begin
      seen <= '0;
      // everything zeroed except the generation, which steps
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt[i] <= (i == int'(CNT_GEN)) ? cnt[i] + 32'd1 : '0;
      end
    end else if (go) begin
      seen <= seen_next;
      for (int i = 0; i < NUM_CNT; i++) cnt[i] <= cnt[i] + 32'(inc[i]);
    end
  end
endmodule
`default_nettype wire

### src/dhcp_rx_frame_classifier_top.sv
// dhcp receive frame classifier
// in channel: one request per cycle while in_stall is low (in_valid, in_data). a request
//   is a frame byte, a frame without payload, a counter read or a statistics clear
// out channel: out_valid, out_stall, out_data. one result per final frame byte, per
//   frame without payload and per counter read; other requests give none
// the result is registered and shows in the cycle after its request is taken
// throughput: one request per cycle while in_stall is low; the parse and the verdict
//   are each one pass of logic behind the byte position register and the capture registers
// the output register holds a result while out_stall is high; in_stall rises
//   only while a held result blocks the next one, so no result is lost
// reset (rst, synchronous): drops any frame in progress, zeroes captured fields
//   and all ten counters, empties the output register
// clear request: the same, except the generation counter is bumped
`default_nettype none
module dhcp_rx_frame_classifier_top
  import dhcp_rx_pkg::*;
#(
  parameter int MAX_FRAME_LEN = 65535
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_data
);
  logic go, is_byte, is_empty, is_read, is_clear, commit, produce;
  capture_t cap_next;
  logic [15:0] len_next;
  out_item_t res;

  // stall only while a held result cannot drain
  assign in_stall = out_valid && out_stall;
  assign go       = in_valid && !in_stall;
  assign is_byte  = in_data.cmd == CMD_BYTE;
  assign is_empty = in_data.cmd == CMD_EMPTY;
  assign is_read  = in_data.cmd == CMD_READ;
  assign is_clear = in_data.cmd == CMD_CLEAR;
  assign commit   = (is_byte && in_data.last_byte) || is_empty;
  assign produce  = commit || is_read;

  dhcp_rx_parser #(.MAX_FRAME_LEN(MAX_FRAME_LEN)) u_parser (
    .clk(clk), .rst(rst),
    .byte_en(go && is_byte),
    .restart(go && (commit || is_clear)),
    .b(in_data.data_byte),
    .cap_next(cap_next),
    .len_next(len_next)
  );

  dhcp_rx_commit u_commit (
    .clk(clk), .rst(rst), .go(go),
    .commit(commit), .empty(is_empty), .read(is_read), .clear(is_clear),
    .cap(cap_next), .len(len_next),
    .iface(in_data.iface), .dst_idx(in_data.dst_idx),
    .counter_index(in_data.counter_index),
    .res(res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= produce;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && produce) begin
      out_data <= res;
    end
  end
endmodule
`default_nettype wire

### src/dhcp_rx_checker.sv
`default_nettype none
module dhcp_rx_checker
  import dhcp_rx_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  a_read: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.cmd == CMD_READ |=> out_valid &&
    out_data.verdict == V_COUNTER)
    else $error("counter read gave no reply");
  a_nores: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.cmd == CMD_CLEAR |=> !out_valid)
    else $error("clear produced a result");
  a_val: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.verdict != V_COUNTER |-> out_data.counter_value == 32'd0)
    else $error("frame verdict with counter value");
endmodule

bind dhcp_rx_frame_classifier_top dhcp_rx_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

### test/tb_dhcp_rx_frame_classifier_top.sv
`default_nettype none
module tb_dhcp_rx_frame_classifier_top;
  import dhcp_rx_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  dhcp_rx_frame_classifier_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // predictor state: frame in progress
  logic [15:0] pos;
  logic [47:0] cap_mac;
  logic [15:0] cap_etype;
  logic [7:0]  cap_ip0;
  logic [7:0]  cap_proto;
  logic [31:0] cap_sip, cap_dip, cap_xid, cap_cookie;
  logic [15:0] cap_sport, cap_dport;
  logic [47:0] cap_chaddr;
  opt_state_t  opt_st;
  logic [7:0]  opt_code, opt_skip, opt_type;
  logic        opt_found;
  // last seen fields and counters
  out_item_t   seen;
  logic [31:0] stats [NUM_CNT];

  out_item_t   expected_results[$];
  int          mismatch_count = 0;
  bit          sender_idle_on = 1'b1;
  bit          receiver_idle_on = 1'b1;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    mismatch_count++;
  endtask

  function automatic void drop_frame();
    pos = '0; cap_mac = '0; cap_etype = '0; cap_ip0 = '0; cap_proto = '0;
    cap_sip = '0; cap_dip = '0; cap_xid = '0; cap_cookie = '0;
    cap_sport = '0; cap_dport = '0; cap_chaddr = '0;
    opt_st = OPT_CODE; opt_code = '0; opt_skip = '0; opt_type = '0; opt_found = 1'b0;
  endfunction

  function automatic void wipe_all();
    drop_frame();
    seen = '0;
    for (int i = 0; i < NUM_CNT; i++) stats[i] = '0;
  endfunction

  function automatic void walk_option(input logic [7:0] b);
    case (opt_st)
      OPT_CODE: begin
        if (b == OPT_END) opt_st = OPT_DONE;
        else if (b != OPT_PAD) begin
          opt_code = b;
          opt_st = OPT_LEN;
        end
      end
      OPT_LEN: begin
        if (opt_code == OPT_MSG_TYPE && b == 8'd1) opt_st = OPT_VALUE;
        else if (b == 8'd0) opt_st = OPT_CODE;
        else begin
          opt_skip = b;
          opt_st = OPT_SKIP;
        end
      end
      OPT_SKIP: begin
        opt_skip = opt_skip - 8'd1;
        if (opt_skip == 8'd0) opt_st = OPT_CODE;
      end
      OPT_VALUE: begin
        opt_type = b;
        opt_found = 1'b1;
        opt_st = OPT_DONE;
      end
      default: ;
    endcase
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    int p, u, d, hl;
    p = int'(pos);
    if (p >= 65535) return;
    hl = cap_ip0[3:0] * 4;
    if (p < 6) cap_mac = {cap_mac[39:0], b};
    if (p == 12 || p == 13) cap_etype = {cap_etype[7:0], b};
    if (p == 14) begin
      cap_ip0 = b;
      hl = b[3:0] * 4;
    end
    if (p == 23) cap_proto = b;
    if (p >= 26 && p < 30) cap_sip = {cap_sip[23:0], b};
    if (p >= 30 && p < 34) cap_dip = {cap_dip[23:0], b};
    u = 14 + hl;
    d = u + 8;
    if (p >= u && p < u + 2) cap_sport = {cap_sport[7:0], b};
    if (p >= u + 2 && p < u + 4) cap_dport = {cap_dport[7:0], b};
    if (p >= d + 4 && p < d + 8) cap_xid = {cap_xid[23:0], b};
    if (p >= d + 28 && p < d + 34) cap_chaddr = {cap_chaddr[39:0], b};
    if (p >= d + 236 && p < d + 240) cap_cookie = {cap_cookie[23:0], b};
    if (p >= d + 240) walk_option(b);
    pos = 16'(p + 1);
  endfunction

  function automatic verdict_t classify(input int len, input logic [7:0] ifc,
                                        input logic [7:0] didx);
    int hl, d;
    logic [7:0] mt;
    stats[CNT_FRAMES]++;
    if (len < 14) begin
      stats[CNT_TRUNC]++;
      return V_TRUNC;
    end
    seen.dest_mac = cap_mac;
    seen.last_iface = ifc;
    seen.last_dst_idx = didx;
    if (cap_etype != ETH_IPV4) return V_NOT_IP;
    stats[CNT_IPV4]++;
    hl = cap_ip0[3:0] * 4;
    if (len < 34 || cap_ip0[7:4] != 4'd4 || hl < 20 || len < 14 + hl + 8) begin
      stats[CNT_TRUNC]++;
      return V_TRUNC;
    end
    seen.src_ip = cap_sip;
    seen.dst_ip = cap_dip;
    if (cap_proto != PROTO_UDP) return V_NOT_UDP;
    stats[CNT_UDP]++;
    seen.udp_sport = cap_sport;
    seen.udp_dport = cap_dport;
    if (cap_sport != PORT_SRV || cap_dport != PORT_CLI) return V_NOT_DH;
    stats[CNT_DHCP]++;
    d = 14 + hl + 8;
    if (len - d < 240 || cap_cookie != MAGIC_COOKIE) begin
      stats[CNT_BADCK]++;
      return V_BAD_CK;
    end
    mt = opt_found ? opt_type : 8'd0;
    seen.xid = cap_xid;
    seen.dhcp_type = mt;
    seen.client_hw_addr = cap_chaddr;
    if (mt == 8'd2) stats[CNT_OFFER]++;
    else if (mt == 8'd5) stats[CNT_ACK]++;
    else if (mt == 8'd6) stats[CNT_NAK]++;
    return V_DHCP_OK;
  endfunction

  function automatic void predict_request(input in_item_t r);
    out_item_t res;
    logic [31:0] g;
    case (cmd_t'(r.cmd))
      CMD_BYTE: begin
        parse_byte(r.data_byte);
        if (r.last_byte) begin
          res = seen;
          res.verdict = classify(int'(pos), r.iface, r.dst_idx);
          res = {res.verdict, seen[$bits(out_item_t)-4:32], 32'd0};
          drop_frame();
          expected_results.push_back(res);
        end
      end
      CMD_EMPTY: begin
        drop_frame();
        res.verdict = classify(0, r.iface, r.dst_idx);
        res = {res.verdict, seen[$bits(out_item_t)-4:32], 32'd0};
        expected_results.push_back(res);
      end
      CMD_READ: begin
        res = {V_COUNTER, seen[$bits(out_item_t)-4:32],
               (r.counter_index < NUM_CNT) ? stats[r.counter_index] : 32'd0};
        expected_results.push_back(res);
      end
      default: begin
        g = stats[CNT_GEN] + 32'd1;
        wipe_all();
        stats[CNT_GEN] = g;
      end
    endcase
  endfunction

  // sends one request, holding it while stalled, with optional random gaps
  task automatic send_request(input in_item_t r);
    if (sender_idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(r);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
  endtask

  function automatic in_item_t noise_fields(input cmd_t c);
    in_item_t r;
    r = in_item_t'(31'($urandom));
    r.cmd = c;
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit last);
    in_item_t r;
    r = noise_fields(CMD_BYTE);
    r.data_byte = b;
    r.last_byte = last;
    send_request(r);
  endtask

  task automatic read_stat(input logic [3:0] idx);
    in_item_t r;
    r = noise_fields(CMD_READ);
    r.counter_index = idx;
    send_request(r);
  endtask

  task automatic send_cmd(input cmd_t c);
    send_request(noise_fields(c));
  endtask

  // frame builder: stage picks where the frame stops being dhcp
  // broken stages end right after the udp header, stage 6 is cut early at random
  task automatic send_frame(input int stage, input logic [7:0] mtype, input int extra);
    logic [7:0] f[$];
    int hl;
    hl = ($urandom_range(0, 3) == 0) ? 4 * $urandom_range(5, 7) : 20;
    for (int i = 0; i < 12; i++) f.push_back(8'($urandom));
    f.push_back(8'h08); f.push_back(stage == 1 ? 8'h06 : 8'h00);
    f.push_back({stage == 2 ? 4'd6 : 4'd4, 4'(hl / 4)});
    for (int i = 1; i < 9; i++) f.push_back(8'($urandom));
    f.push_back(stage == 3 ? 8'd6 : PROTO_UDP);
    for (int i = 24; i < 14 + hl; i++) f.push_back(8'($urandom));
    f.push_back(8'd0); f.push_back(stage == 4 ? 8'd68 : 8'd67);
    f.push_back(8'd0); f.push_back(8'd68);
    for (int i = 0; i < 4; i++) f.push_back(8'($urandom));
    for (int i = 0; i < 236; i++) f.push_back(8'($urandom));
    f.push_back(8'd99); f.push_back(8'd130);
    f.push_back(8'd83); f.push_back(8'd99);
    // options: pad, a skipped option, zero-length option, then type
    f.push_back(OPT_PAD);
    f.push_back(8'd12); f.push_back(8'd2);
    f.push_back(8'($urandom)); f.push_back(8'($urandom));
    f.push_back(8'd61); f.push_back(8'd0);
    f.push_back(OPT_MSG_TYPE); f.push_back(8'd1); f.push_back(mtype);
    f.push_back(OPT_END);
    for (int i = 0; i < extra; i++) f.push_back(8'($urandom));
    if (stage >= 1 && stage <= 5) f = f[0:14 + hl + 7];
    if (stage == 6) f = f[0:$urandom_range(0, 59)];
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (expected_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", out_data.verdict, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.verdict !== want.verdict) report("verdict", out_data.verdict, want.verdict);
        if (out_data.dhcp_type !== want.dhcp_type)
          report("dhcp_type", out_data.dhcp_type, want.dhcp_type);
        if (out_data.xid !== want.xid) report("xid", out_data.xid, want.xid);
        if (out_data.client_hw_addr !== want.client_hw_addr)
          report("client_hw_addr", out_data.client_hw_addr, want.client_hw_addr);
        if (out_data.src_ip !== want.src_ip) report("src_ip", out_data.src_ip, want.src_ip);
        if (out_data.dst_ip !== want.dst_ip) report("dst_ip", out_data.dst_ip, want.dst_ip);
        if (out_data.udp_sport !== want.udp_sport)
          report("udp_sport", out_data.udp_sport, want.udp_sport);
        if (out_data.udp_dport !== want.udp_dport)
          report("udp_dport", out_data.udp_dport, want.udp_dport);
        if (out_data.dest_mac !== want.dest_mac)
          report("dest_mac", out_data.dest_mac, want.dest_mac);
        if (out_data.last_iface !== want.last_iface)
          report("last_iface", out_data.last_iface, want.last_iface);
        if (out_data.last_dst_idx !== want.last_dst_idx)
          report("last_dst_idx", out_data.last_dst_idx, want.last_dst_idx);
        if (out_data.counter_value !== want.counter_value)
          report("counter_value", out_data.counter_value, want.counter_value);
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (!receiver_idle_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end else if ($urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(1, 12);
      out_stall <= 1'b1;
    end
  end

  // reads every counter, including an index past the last one
  task automatic test_counter_reads();
    for (int i = 0; i < 16; i++) read_stat(4'(i));
  endtask

  // one frame per verdict plus empty frame, short frame and message type
  task automatic test_directed_frames();
    send_cmd(CMD_EMPTY);
    send_byte(8'hff, 1'b1);
    send_frame(0, 8'd2, 0);
    for (int s = 1; s <= 5; s++) send_frame(s, 8'd1, 0);
    send_byte(8'h00, 1'b0);
    send_cmd(CMD_EMPTY);
    test_counter_reads();
  endtask

  // clear drops a frame in progress and bumps the generation
  task automatic test_clear();
    send_byte(8'h12, 1'b0);
    send_cmd(CMD_CLEAR);
    send_cmd(CMD_CLEAR);
    read_stat(CNT_GEN);
    read_stat(CNT_FRAMES);
    send_byte(8'h00, 1'b1);
  endtask

  // random mix of broken frames, loose bytes and commands
  task automatic test_random(input int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 6) send_frame($urandom_range(1, 6), 8'($urandom_range(0, 8)), 0);
      else if (sel < 45) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      else if (sel < 55) send_cmd(CMD_EMPTY);
      else if (sel < 92) read_stat(4'($urandom_range(0, 15)));
      else send_cmd(CMD_CLEAR);
    end
  endtask

  initial begin
    wipe_all();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frames();
    test_clear();
    // hold the sender until everything expected has come back
    go_idle();
    wait_drained();
    test_random(30);
    sender_idle_on = 1'b0;
    receiver_idle_on = 1'b0;
    test_random(12);
    test_counter_reads();
    go_idle();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

### dhcp_rx_frame_classifier_top.f
src/dhcp_rx_pkg.sv
src/dhcp_rx_parser.sv
src/dhcp_rx_commit.sv
src/dhcp_rx_frame_classifier_top.sv
src/dhcp_rx_checker.sv
test/tb_dhcp_rx_frame_classifier_top.sv
